>>> src/bresenham_line_rasterizer_unit_assert.svh
// Assertion macros shared by the line rasterizer RTL.
// Included by bresenham_line_rasterizer_unit.sv; no other dependencies.
`ifndef BRESENHAM_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define BRLU_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line rasterizer assertion failed");

// Next-cycle implication, checked out of reset only.
`define BRLU_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line rasterizer assertion failed");

`endif

>>> src/brlu_pkg.sv
// Shared types and constants for the line rasterizer.
// No dependencies; imported by every RTL module.
`timescale 1ns / 1ps

package brlu_pkg;

    // configuration register file
    localparam int CFG_W      = 11;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;

    localparam logic [CFG_W-1:0] IMAGE_DIM_RESET = 11'd1024;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_NEXT  = 1'b1;

    localparam int COLOUR_W = 16;

    // flags of a pixel travelling from the stepper to the output stage
    typedef struct packed {
        logic pixel_valid;
        logic last_pixel;
    } pix_flags_t;

endpackage

>>> src/brlu_req_if.sv
// Request and pixel channel interfaces (valid/ready plus payload).
// Depends on brlu_pkg for the colour width.
`timescale 1ns / 1ps

interface brlu_req_if
    import brlu_pkg::*;
#(
    parameter int MAX_DIM = 1024
);
    localparam int CW = $clog2(MAX_DIM);

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [CW-1:0]       x_start;
    logic [CW-1:0]       y_start;
    logic [CW-1:0]       x_end;
    logic [CW-1:0]       y_end;
    logic [COLOUR_W-1:0] pen_colour;

    modport source (output valid, req_type, x_start, y_start, x_end, y_end, pen_colour,
                    input ready);
    modport sink   (input valid, req_type, x_start, y_start, x_end, y_end, pen_colour,
                    output ready);
endinterface

interface brlu_pix_if
    import brlu_pkg::*;
#(
    parameter int MAX_DIM = 1024
);
    localparam int CW = $clog2(MAX_DIM);

    logic                valid;
    logic                ready;
    logic                pixel_valid;
    logic [CW-1:0]       pixel_x;
    logic [CW-1:0]       pixel_y;
    logic [2*CW-1:0]     pixel_index;
    logic [COLOUR_W-1:0] pixel_colour;
    logic                outside_image;
    logic                last_pixel;

    modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_index, pixel_colour,
                    outside_image, last_pixel, input ready);
    modport sink   (input valid, pixel_valid, pixel_x, pixel_y, pixel_index, pixel_colour,
                    outside_image, last_pixel, output ready);
endinterface

>>> src/brlu_cfg_regs.sv
// APB-style register file holding image width and height.
// Depends on brlu_pkg.
`timescale 1ns / 1ps

module brlu_cfg_regs
    import brlu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CFG_W-1:0]      image_width,
    output logic [CFG_W-1:0]      image_height
);

    logic [CFG_W-1:0]     width_reg,  width_next;
    logic [CFG_W-1:0]     height_reg, height_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        prdata      = '0;
        case (reg_idx)
            REG_IMAGE_WIDTH:
            begin
                prdata = APB_DATA_W'(width_reg);
                if (wr_en)
                begin
                    width_next = pwdata[CFG_W-1:0];
                end
            end
            REG_IMAGE_HEIGHT:
            begin
                prdata = APB_DATA_W'(height_reg);
                if (wr_en)
                begin
                    height_next = pwdata[CFG_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_DIM_RESET;
            height_reg <= IMAGE_DIM_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign image_width  = width_reg;
    assign image_height = height_reg;

endmodule

>>> src/brlu_stepper.sv
// Line state, start setup and one Bresenham step per accepted next request; registers the pixel.
// Depends on brlu_pkg.
`timescale 1ns / 1ps

module brlu_stepper
    import brlu_pkg::*;
#(
    parameter int MAX_DIM = 1024,
    localparam int CW = $clog2(MAX_DIM)
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic                req_type,
    input  logic [CW-1:0]       x_start,
    input  logic [CW-1:0]       y_start,
    input  logic [CW-1:0]       x_end,
    input  logic [CW-1:0]       y_end,
    input  logic [COLOUR_W-1:0] pen_colour,
    output logic                line_active,
    output pix_flags_t          s1_flags,
    output logic [CW-1:0]       s1_x,
    output logic [CW-1:0]       s1_y,
    output logic [COLOUR_W-1:0] s1_colour
);

    localparam int EW = CW + 2;  // signed error term

    logic [CW-1:0]        cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [CW-1:0]        goal_x_reg, goal_x_next, goal_y_reg, goal_y_next;
    logic [CW-1:0]        delta_x_reg, delta_x_next, delta_y_reg, delta_y_next;
    logic                 step_x_neg_reg, step_x_neg_next, step_y_neg_reg, step_y_neg_next;
    logic signed [EW-1:0] err_reg, err_next;
    logic [COLOUR_W-1:0]  colour_reg, colour_next;
    logic                 active_reg, active_next;

    pix_flags_t           s1_flags_reg, s1_flags_next;
    logic [CW-1:0]        s1_x_reg, s1_x_next, s1_y_reg, s1_y_next;
    logic [COLOUR_W-1:0]  s1_colour_reg, s1_colour_next;

    // start setup
    logic [CW-1:0]        dx_new, dy_new;
    logic signed [EW-1:0] half_dx, half_dy, err_start;
    logic                 last_start;

    // one step
    logic signed [EW-1:0] dx_s, dy_s, err_step;
    logic                 move_x, move_y, last_step;
    logic [CW-1:0]        x_step, y_step;

    always_comb
    begin
        dx_new     = (x_end > x_start) ? x_end - x_start : x_start - x_end;
        dy_new     = (y_end > y_start) ? y_end - y_start : y_start - y_end;
        half_dx    = signed'({2'b00, dx_new >> 1});
        half_dy    = signed'({2'b00, dy_new >> 1});
        err_start  = (dx_new > dy_new) ? half_dx : -half_dy;
        last_start = (x_start == x_end) && (y_start == y_end);

        dx_s      = signed'({2'b00, delta_x_reg});
        dy_s      = signed'({2'b00, delta_y_reg});
        move_x    = err_reg > -dx_s;
        move_y    = err_reg < dy_s;
        err_step  = err_reg - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
        x_step    = move_x ? (step_x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1)
                           : cur_x_reg;
        y_step    = move_y ? (step_y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1)
                           : cur_y_reg;
        last_step = (x_step == goal_x_reg) && (y_step == goal_y_reg);
    end

    always_comb
    begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        goal_x_next     = goal_x_reg;
        goal_y_next     = goal_y_reg;
        delta_x_next    = delta_x_reg;
        delta_y_next    = delta_y_reg;
        step_x_neg_next = step_x_neg_reg;
        step_y_neg_next = step_y_neg_reg;
        err_next        = err_reg;
        colour_next     = colour_reg;
        active_next     = active_reg;
        s1_flags_next   = s1_flags_reg;
        s1_x_next       = s1_x_reg;
        s1_y_next       = s1_y_reg;
        s1_colour_next  = s1_colour_reg;

        if (take)
        begin
            if (req_type == REQ_START)
            begin
                cur_x_next      = x_start;
                cur_y_next      = y_start;
                goal_x_next     = x_end;
                goal_y_next     = y_end;
                delta_x_next    = dx_new;
                delta_y_next    = dy_new;
                step_x_neg_next = !(x_start < x_end);
                step_y_neg_next = !(y_start < y_end);
                err_next        = err_start;
                colour_next     = pen_colour;
                active_next     = !last_start;
                s1_flags_next   = '{pixel_valid: 1'b1, last_pixel: last_start};
                s1_x_next       = x_start;
                s1_y_next       = y_start;
                s1_colour_next  = pen_colour;
            end
            else if (active_reg)
            begin
                cur_x_next     = x_step;
                cur_y_next     = y_step;
                err_next       = err_step;
                active_next    = !last_step;
                s1_flags_next  = '{pixel_valid: 1'b1, last_pixel: last_step};
                s1_x_next      = x_step;
                s1_y_next      = y_step;
                s1_colour_next = colour_reg;
            end
            else
            begin
                // no line: all-zero result
                s1_flags_next  = '0;
                s1_x_next      = '0;
                s1_y_next      = '0;
                s1_colour_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            goal_x_reg     <= '0;
            goal_y_reg     <= '0;
            delta_x_reg    <= '0;
            delta_y_reg    <= '0;
            step_x_neg_reg <= 1'b0;
            step_y_neg_reg <= 1'b0;
            err_reg        <= '0;
            colour_reg     <= '0;
            active_reg     <= 1'b0;
            s1_flags_reg   <= '0;
        end
        else
        begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            goal_x_reg     <= goal_x_next;
            goal_y_reg     <= goal_y_next;
            delta_x_reg    <= delta_x_next;
            delta_y_reg    <= delta_y_next;
            step_x_neg_reg <= step_x_neg_next;
            step_y_neg_reg <= step_y_neg_next;
            err_reg        <= err_next;
            colour_reg     <= colour_next;
            active_reg     <= active_next;
            s1_flags_reg   <= s1_flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg      <= s1_x_next;
        s1_y_reg      <= s1_y_next;
        s1_colour_reg <= s1_colour_next;
    end

    assign line_active = active_reg;
    assign s1_flags    = s1_flags_reg;
    assign s1_x        = s1_x_reg;
    assign s1_y        = s1_y_reg;
    assign s1_colour   = s1_colour_reg;

endmodule

>>> src/brlu_pixel_stage.sv
// Bounds check and frame-buffer index for one pixel, into the output register.
// Depends on brlu_pkg and brlu_pix_if.
`timescale 1ns / 1ps

module brlu_pixel_stage
    import brlu_pkg::*;
#(
    parameter int MAX_DIM = 1024,
    localparam int CW = $clog2(MAX_DIM)
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s1_valid,
    input  pix_flags_t          s1_flags,
    input  logic [CW-1:0]       s1_x,
    input  logic [CW-1:0]       s1_y,
    input  logic [COLOUR_W-1:0] s1_colour,
    input  logic [CFG_W-1:0]    image_width,
    input  logic [CFG_W-1:0]    image_height,
    output logic                adv,
    brlu_pix_if.source          pix
);

    localparam int IW   = 2 * CW;
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;
    localparam int SW   = (2 * CFG_W + 1 > IW) ? 2 * CFG_W + 1 : IW;

    logic [CMPW-1:0]     x_ext, y_ext, w_ext, h_ext, row_wide;
    logic [CFG_W-1:0]    row;
    logic [2*CFG_W-1:0]  prod;
    logic [SW-1:0]       sum;
    logic                outside;

    logic                out_valid_reg, out_valid_next;
    pix_flags_t          flags_reg;
    logic                outside_reg;
    logic [CW-1:0]       x_reg, y_reg;
    logic [IW-1:0]       index_reg;
    logic [COLOUR_W-1:0] colour_reg;

    always_comb
    begin
        x_ext    = CMPW'(s1_x);
        y_ext    = CMPW'(s1_y);
        w_ext    = CMPW'(image_width);
        h_ext    = CMPW'(image_height);
        outside  = s1_flags.pixel_valid && ((x_ext >= w_ext) || (y_ext >= h_ext));
        // bottom-up row; below the height whenever the pixel is inside
        row_wide = h_ext - y_ext - 1'b1;
        row      = row_wide[CFG_W-1:0];
        prod     = row * image_width;
        sum      = SW'(prod) + SW'(s1_x);
    end

    assign adv            = !out_valid_reg || pix.ready;
    assign out_valid_next = adv ? s1_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid)
        begin
            flags_reg   <= s1_flags;
            outside_reg <= outside;
            x_reg       <= s1_x;
            y_reg       <= s1_y;
            colour_reg  <= s1_colour;
            index_reg   <= (outside || !s1_flags.pixel_valid) ? '0 : sum[IW-1:0];
        end
    end

    assign pix.valid         = out_valid_reg;
    assign pix.pixel_valid   = flags_reg.pixel_valid;
    assign pix.last_pixel    = flags_reg.last_pixel;
    assign pix.outside_image = outside_reg;
    assign pix.pixel_x       = x_reg;
    assign pix.pixel_y       = y_reg;
    assign pix.pixel_index   = index_reg;
    assign pix.pixel_colour  = colour_reg;

endmodule

>>> src/bresenham_line_rasterizer_unit.sv
// Line rasterizer top level: request/pixel channels, APB image-size registers, checks.
// A taken request is registered in stage 1 (stepper output), then in the output stage that drives pix.
// Throughput: one request per cycle; ready drops only while both stages hold a pixel and
//   the pixel side stalls.
// Reset (rst_n, async, active low): no line active, both stages empty, image 1024 x 1024.
// Depends on brlu_pkg, brlu_req_if/brlu_pix_if, brlu_cfg_regs, brlu_stepper, brlu_pixel_stage.
`timescale 1ns / 1ps
`include "bresenham_line_rasterizer_unit_assert.svh"

module bresenham_line_rasterizer_unit
    import brlu_pkg::*;
#(
    parameter int MAX_DIM = 1024
)(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel: start a line or ask for the next pixel
    brlu_req_if.sink              req,
    // pixel channel: one pixel transaction per request transaction
    brlu_pix_if.source            pix,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CW = $clog2(MAX_DIM);

    logic [CFG_W-1:0]    image_width;
    logic [CFG_W-1:0]    image_height;

    // stage 1 (stepper output register) occupancy
    logic                s1_valid_reg, s1_valid_next;
    logic                take;
    logic                adv;
    logic                line_active;
    pix_flags_t          s1_flags;
    logic [CW-1:0]       s1_x;
    logic [CW-1:0]       s1_y;
    logic [COLOUR_W-1:0] s1_colour;

    brlu_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .image_width  (image_width),
        .image_height (image_height)
    );

    // Stage 1 accepts whenever it is empty or drains into the output stage
    // in the same cycle, so back-to-back requests flow at one per clock.
    assign req.ready = !s1_valid_reg || adv;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Line state lives here: endpoints, deltas, step signs, error term.
    // A start request sets it up and yields the start pixel; a next request
    // performs one add/compare Bresenham step while a line is active.
    brlu_stepper #(
        .MAX_DIM (MAX_DIM)
    ) u_stepper (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .req_type    (req.req_type),
        .x_start     (req.x_start),
        .y_start     (req.y_start),
        .x_end       (req.x_end),
        .y_end       (req.y_end),
        .pen_colour  (req.pen_colour),
        .line_active (line_active),
        .s1_flags    (s1_flags),
        .s1_x        (s1_x),
        .s1_y        (s1_y),
        .s1_colour   (s1_colour)
    );

    // Bounds check and bottom-up word index (one 11x11 multiply + add),
    // registered into the output transaction.
    brlu_pixel_stage #(
        .MAX_DIM (MAX_DIM)
    ) u_pixel (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid_reg),
        .s1_flags     (s1_flags),
        .s1_x         (s1_x),
        .s1_y         (s1_y),
        .s1_colour    (s1_colour),
        .image_width  (image_width),
        .image_height (image_height),
        .adv          (adv),
        .pix          (pix)
    );

    // An invalid result carries all-zero fields.
    `BRLU_ASSERT_IMPL(a_invalid_zero, clk, rst_n, pix.valid && !pix.pixel_valid, pix.pixel_x == '0 && pix.pixel_y == '0 && pix.pixel_index == '0 && !pix.last_pixel && !pix.outside_image)
    // Out-of-image pixels never carry a frame-buffer index.
    `BRLU_ASSERT_IMPL(a_outside_no_index, clk, rst_n, pix.valid && pix.outside_image, pix.pixel_index == '0)
    // The final pixel of a line leaves no line active behind it.
    `BRLU_ASSERT_IMPL(a_last_ends_line, clk, rst_n, s1_valid_reg && s1_flags.last_pixel, !line_active)
    // An invalid pixel only comes from a step with no line.
    `BRLU_ASSERT_IMPL(a_invalid_idle, clk, rst_n, s1_valid_reg && !s1_flags.pixel_valid, !line_active)
    // Every accepted request lands in stage 1.
    `BRLU_ASSERT_NEXT(a_take_fills, clk, rst_n, take, s1_valid_reg)

endmodule

>>> dv/bresenham_line_rasterizer_unit_tb.sv
// Self-checking testbench for bresenham_line_rasterizer_unit: a line-stepping predictor in a
// small scoreboard class, valid/ready request and pixel drivers, and APB register writes.
// Depends on brlu_pkg, brlu_req_if/brlu_pix_if and the RTL top level.
`timescale 1ns / 1ps

module bresenham_line_rasterizer_unit_tb
    import brlu_pkg::*;
();

    localparam int MAX_DIM     = 1024;
    localparam int COORD_W     = 10;
    localparam int INDEX_W     = 2 * COORD_W;
    localparam int LONG_HOLD   = 200;      // one long pixel-side stall, in cycles
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 240;

    // One request transaction as the sender builds it.
    typedef struct packed {
        logic                req_type;
        logic [COORD_W-1:0]  x_start;
        logic [COORD_W-1:0]  y_start;
        logic [COORD_W-1:0]  x_end;
        logic [COORD_W-1:0]  y_end;
        logic [COLOUR_W-1:0] pen_colour;
    } line_req_t;

    // One pixel transaction, field for field as it leaves the block.
    typedef struct packed {
        logic                pixel_valid;
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [INDEX_W-1:0]  pixel_index;
        logic [COLOUR_W-1:0] pixel_colour;
        logic                outside_image;
        logic                last_pixel;
    } pixel_t;

    // ------------------------------------------------------------------
    // Scoreboard: tracks the line being drawn, turns each accepted request
    // into the pixel it must produce, and checks pixels in order.
    // ------------------------------------------------------------------
    class line_pixel_scoreboard;
        int unsigned         error_count;
        int unsigned         pixel_count;
        logic [CFG_W-1:0]    image_width;
        logic [CFG_W-1:0]    image_height;
        logic [COORD_W-1:0]  cur_x, cur_y, goal_x, goal_y;
        int                  delta_x, delta_y, error_term;
        bit                  x_backward, y_backward;
        logic [COLOUR_W-1:0] line_colour;
        bit                  line_active;
        pixel_t              pending_pixels[$];

        function new();
            image_width  = IMAGE_DIM_RESET;
            image_height = IMAGE_DIM_RESET;
            cur_x = '0; cur_y = '0; goal_x = '0; goal_y = '0;
            delta_x = 0; delta_y = 0; error_term = 0;
            x_backward = 1'b0; y_backward = 1'b0;
            line_colour = '0;
            line_active = 1'b0;
            error_count = 0;
            pixel_count = 0;
        endfunction

        task report(string msg);
            error_count++;
            $display("[tb] %0t: %s", $time, msg);
        endtask

        function void set_dim(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == REG_IMAGE_WIDTH)
                image_width = value;
            else
                image_height = value;
        endfunction

        // Pixel at the current position, with the dimensions in force now.
        function pixel_t pixel_here(bit last);
            pixel_t p;
            bit     outside;
            longint row;
            longint idx;
            p = '0;
            outside = (cur_x >= image_width) || (cur_y >= image_height);
            if (!outside)
            begin
                row = longint'(image_height) - longint'(cur_y) - 1;
                idx = row * longint'(image_width) + longint'(cur_x);
                p.pixel_index = idx[INDEX_W-1:0];
            end
            p.pixel_valid   = 1'b1;
            p.pixel_x       = cur_x;
            p.pixel_y       = cur_y;
            p.pixel_colour  = line_colour;
            p.outside_image = outside;
            p.last_pixel    = last;
            return p;
        endfunction

        function void note_request(line_req_t r);
            pixel_t p;
            bit     last;
            int     e2;
            if (r.req_type == REQ_START)
            begin
                line_colour = r.pen_colour;
                cur_x  = r.x_start;
                cur_y  = r.y_start;
                goal_x = r.x_end;
                goal_y = r.y_end;
                delta_x = (r.x_end > r.x_start) ? int'(r.x_end) - int'(r.x_start)
                                                : int'(r.x_start) - int'(r.x_end);
                delta_y = (r.y_end > r.y_start) ? int'(r.y_end) - int'(r.y_start)
                                                : int'(r.y_start) - int'(r.y_end);
                x_backward = !(r.x_start < r.x_end);
                y_backward = !(r.y_start < r.y_end);
                // half the major delta, truncated toward zero
                error_term = (delta_x > delta_y ? delta_x : -delta_y) / 2;
                last = (cur_x == goal_x) && (cur_y == goal_y);
                line_active = !last;
                p = pixel_here(last);
            end
            else if (!line_active)
            begin
                p = '0;
            end
            else
            begin
                e2 = error_term;
                if (e2 > -delta_x)
                begin
                    error_term -= delta_y;
                    cur_x = x_backward ? cur_x - 1'b1 : cur_x + 1'b1;
                end
                if (e2 < delta_y)
                begin
                    error_term += delta_x;
                    cur_y = y_backward ? cur_y - 1'b1 : cur_y + 1'b1;
                end
                last = (cur_x == goal_x) && (cur_y == goal_y);
                if (last)
                    line_active = 1'b0;
                p = pixel_here(last);
            end
            pending_pixels.push_back(p);
        endfunction

        task check_pixel(pixel_t got);
            pixel_t      want;
            logic [63:0] g [7];
            logic [63:0] w [7];
            string       field_name [7];
            field_name = '{"pixel_valid", "pixel_x", "pixel_y", "pixel_index",
                           "pixel_colour", "outside_image", "last_pixel"};
            if (pending_pixels.size() == 0)
            begin
                report("pixel transaction with no request outstanding");
                return;
            end
            want = pending_pixels.pop_front();
            g = '{got.pixel_valid, got.pixel_x, got.pixel_y, got.pixel_index,
                  got.pixel_colour, got.outside_image, got.last_pixel};
            w = '{want.pixel_valid, want.pixel_x, want.pixel_y, want.pixel_index,
                  want.pixel_colour, want.outside_image, want.last_pixel};
            for (int k = 0; k < 7; k++)
                if (g[k] !== w[k])
                    report($sformatf("pixel #%0d %s: got 0x%0h, want 0x%0h",
                                     pixel_count, field_name[k], g[k], w[k]));
            pixel_count++;
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------
    logic clk;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    brlu_req_if #(.MAX_DIM(MAX_DIM)) req_ch ();
    brlu_pix_if #(.MAX_DIM(MAX_DIM)) pix_ch ();

    bresenham_line_rasterizer_unit #(.MAX_DIM(MAX_DIM)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .pix     (pix_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    line_pixel_scoreboard sb;
    bit                   no_idle;       // both sides run back to back in this phase
    bit                   hold_request;  // asks the pixel side for one long stall
    int unsigned          cycle_count = 0;

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[bresenham_line_rasterizer_unit] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request side. Everything is driven at the falling edge; a transaction
    // is taken at the rising edge where valid and ready are both high.
    // valid stays up across back-to-back requests so it is never lowered
    // and raised again within one time step.
    // ------------------------------------------------------------------
    task automatic send_request(line_req_t r);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= r.req_type;
        req_ch.x_start    <= r.x_start;
        req_ch.y_start    <= r.y_start;
        req_ch.x_end      <= r.x_end;
        req_ch.y_end      <= r.y_end;
        req_ch.pen_colour <= r.pen_colour;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(r);
        @(negedge clk);
    endtask

    function automatic line_req_t start_req(int x0, int y0, int x1, int y1, int colour);
        line_req_t r;
        r.req_type   = REQ_START;
        r.x_start    = x0[COORD_W-1:0];
        r.y_start    = y0[COORD_W-1:0];
        r.x_end      = x1[COORD_W-1:0];
        r.y_end      = y1[COORD_W-1:0];
        r.pen_colour = colour[COLOUR_W-1:0];
        return r;
    endfunction

    // Next-pixel request; the coordinate and colour fields are don't-care
    // for the block, so they carry noise.
    function automatic line_req_t next_req();
        line_req_t r;
        r = start_req($urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1),
                      $urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1),
                      $urandom_range(0, 65535));
        r.req_type = REQ_NEXT;
        return r;
    endfunction

    function automatic int clamp_coord(int v);
        if (v < 0)
            return 0;
        if (v > MAX_DIM - 1)
            return MAX_DIM - 1;
        return v;
    endfunction

    // Random line: mostly short so many complete lines fit, a few medium,
    // and now and then endpoints anywhere on the full range.
    function automatic void make_line(output line_req_t r, output int steps);
        int x0, y0, x1, y1, span, pick, dx, dy;
        pick = $urandom_range(0, 99);
        x0 = $urandom_range(0, MAX_DIM - 1);
        y0 = $urandom_range(0, MAX_DIM - 1);
        if (pick < 4)
        begin
            x1 = $urandom_range(0, MAX_DIM - 1);
            y1 = $urandom_range(0, MAX_DIM - 1);
        end
        else
        begin
            span = (pick < 80) ? 15 : 120;
            x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * span)) - span);
            y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * span)) - span);
        end
        r  = start_req(x0, y0, x1, y1, $urandom_range(0, 65535));
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        steps = (dx > dy) ? dx : dy;
    endfunction

    // Mostly whole lines walked to their end point; some are cut short by a
    // fresh start, some are stepped past the end, and a few stray next
    // requests land wherever they land. A phase may end mid-line, so the
    // register write that follows changes the dimensions under a live line.
    task automatic random_traffic(int n);
        line_req_t r;
        int        sent;
        int        steps;
        int        pick;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                send_request(next_req());
                sent++;
            end
            else
            begin
                make_line(r, steps);
                if (pick < 14)
                    steps = $urandom_range(0, steps);
                else if (pick < 20)
                    steps += $urandom_range(1, 3);
                send_request(r);
                sent++;
                for (int k = 0; k < steps && sent < n; k++)
                begin
                    send_request(next_req());
                    sent++;
                end
            end
        end
    endtask

    // Drop valid and wait until every pixel is back; the block is idle then.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // APB register access: setup cycle, then access cycle.
    // ------------------------------------------------------------------
    task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        logic [APB_DATA_W-1:0] data;
        // unused upper bits carry noise
        data = ($urandom() & ~APB_DATA_W'(2 ** CFG_W - 1)) | APB_DATA_W'(value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_dim(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic read_register(logic [REG_IDX_W-1:0] idx);
        logic [APB_DATA_W-1:0] got;
        logic [APB_DATA_W-1:0] want;
        want = APB_DATA_W'((idx == REG_IMAGE_WIDTH) ? sb.image_width : sb.image_height);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        if (got !== want)
            sb.report($sformatf("register %0d read: got 0x%0h, want 0x%0h", idx, got, want));
    endtask

    // ------------------------------------------------------------------
    // Pixel side: draws a stall before each transaction, except for one
    // long hold-off that lets the pipeline fill and back up the requests.
    // ------------------------------------------------------------------
    initial
    begin : pixel_sink
        pixel_t      got;
        int unsigned gap;
        pix_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 19);
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap = LONG_HOLD;
            end
            if (gap > 0)
            begin
                pix_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pix_ch.ready <= 1'b1;
            do @(posedge clk); while (!pix_ch.valid);
            got.pixel_valid   = pix_ch.pixel_valid;
            got.pixel_x       = pix_ch.pixel_x;
            got.pixel_y       = pix_ch.pixel_y;
            got.pixel_index   = pix_ch.pixel_index;
            got.pixel_colour  = pix_ch.pixel_colour;
            got.outside_image = pix_ch.outside_image;
            got.last_pixel    = pix_ch.last_pixel;
            sb.check_pixel(got);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] phase_width  [PHASES];
    logic [CFG_W-1:0] phase_height [PHASES];

    initial
    begin : main_sequence
        sb           = new();
        no_idle      = 1'b0;
        hold_request = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_START;
        req_ch.x_start    = '0;
        req_ch.y_start    = '0;
        req_ch.x_end      = '0;
        req_ch.y_end      = '0;
        req_ch.pen_colour = '0;

        // dimension settings per phase: ordinary, zero (all outside), one,
        // the 11-bit maximum (index wraps), one-row and one-column images,
        // a random pair, and back to the reset size
        phase_width  = '{11'd640, 11'd0, 11'd1, 11'd2047, 11'd1024, 11'd1, 11'd0, 11'd1024};
        phase_height = '{11'd480, 11'd0, 11'd1, 11'd2047, 11'd1, 11'd1024, 11'd0, 11'd1024};
        phase_width[6]  = $urandom_range(0, 2047);
        phase_height[6] = $urandom_range(0, 2047);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset values of the dimension registers
        read_register(REG_IMAGE_WIDTH);
        read_register(REG_IMAGE_HEIGHT);

        // Directed part at the reset size (1024 x 1024).
        send_request(next_req());                                  // next, no line yet
        send_request(start_req(0, 0, 0, 0, 16'h0000));            // single point, corner
        send_request(next_req());                                  // nothing left after it
        send_request(start_req(1023, 1023, 1023, 1023, 16'hFFFF)); // single point, far corner
        send_request(start_req(0, 0, 1023, 1023, 16'hA5A5));       // long diagonal
        send_request(next_req());
        send_request(next_req());
        send_request(start_req(1023, 0, 0, 1023, 16'h5A5A));       // restart drops the old line
        send_request(next_req());
        send_request(next_req());
        send_request(start_req(5, 5, 9, 5, 16'h1234));             // horizontal, to its end
        repeat (4) send_request(next_req());
        send_request(next_req());                                  // stepped past the end
        send_request(start_req(7, 9, 7, 6, 16'hF800));             // vertical, upward
        repeat (3) send_request(next_req());
        send_request(start_req(10, 3, 6, 11, 16'h07E0));           // steep, leftward
        send_request(next_req());
        send_request(next_req());
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_register(REG_IMAGE_WIDTH, phase_width[ph]);
            write_register(REG_IMAGE_HEIGHT, phase_height[ph]);
            read_register(REG_IMAGE_WIDTH);
            read_register(REG_IMAGE_HEIGHT);
            no_idle = (ph % 3 == 2);
            // one long pixel-side stall while requests keep coming
            if (ph == 2)
                hold_request = 1'b1;
            random_traffic(PHASE_ITEMS);
            drain();
        end
        no_idle = 1'b0;

        repeat (10) @(posedge clk);
        if (sb.pending_pixels.size() != 0)
            sb.report($sformatf("%0d pixels never arrived", sb.pending_pixels.size()));

        if (sb.error_count == 0)
            $display("[bresenham_line_rasterizer_unit] OK");
        else
            $display("[bresenham_line_rasterizer_unit] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/brlu_pkg.sv
src/brlu_req_if.sv
src/brlu_cfg_regs.sv
src/brlu_stepper.sv
src/brlu_pixel_stage.sv
src/bresenham_line_rasterizer_unit.sv
dv/bresenham_line_rasterizer_unit_tb.sv
